/* design/wifi_he_ie_scanner_core_assert.svh */
// assertion macros used by the scanner back end
`ifndef WIFI_HE_IE_SCANNER_CORE_ASSERT_SVH
`define WIFI_HE_IE_SCANNER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WIFIHE_ASSERT_IMPLY(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define WIFIHE_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/wifihe_pkg.sv */
package wifihe_pkg;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_ELEM_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HE_CAP_EXT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HE_OP_EXT   = 2'd2;

	localparam logic [7:0] EXT_ELEM_ID_RST = 8'd255;
	localparam logic [7:0] HE_CAP_EXT_RST  = 8'd35;
	localparam logic [7:0] HE_OP_EXT_RST   = 8'd36;

	// front to back queue
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// element layout
	localparam logic [7:0] MAC_LEN    = 8'd6;
	localparam logic [7:0] PHY_LEN    = 8'd11;
	localparam logic [7:0] CAP_MIN    = MAC_LEN + PHY_LEN;
	localparam logic [7:0] OP_MIN_LEN = 8'd4;
	localparam logic [7:0] IDX_MAC1   = 8'd1;
	localparam logic [7:0] IDX_MAC3   = 8'd3;
	localparam logic [7:0] IDX_OP0    = 8'd0;

	// capability bits
	localparam logic [7:0] PHY_BW160  = 8'h40;
	localparam logic [7:0] PHY_BW80   = 8'h04;
	localparam logic [7:0] PHY_BW40   = 8'h02;
	localparam logic [7:0] PHY_MUMIMO = 8'h01;
	localparam logic [7:0] PHY_6GHZ   = 8'h20;
	localparam logic [7:0] MAC_OFDMA  = 8'h80;
	localparam logic [7:0] MAC_TWT    = 8'h06;
	localparam logic [7:0] OP_TWT     = 8'h02;
	localparam logic [7:0] COLOR_MASK = 8'h3f;

	localparam logic [7:0] MHZ_160 = 8'd160;
	localparam logic [7:0] MHZ_80  = 8'd80;
	localparam logic [7:0] MHZ_40  = 8'd40;
	localparam logic [7:0] MHZ_20  = 8'd20;

	typedef enum logic [1:0] {
		PH_ID,
		PH_LEN,
		PH_EXT,
		PH_BODY
	} phase_t;

	typedef enum logic [1:0] {
		ST_NO_HE    = 2'd0,
		ST_HE_OK    = 2'd1,
		ST_CAP_SHORT = 2'd2
	} status_t;

	// classified byte as it travels from front to back
	typedef struct packed {
		logic [7:0] ie_byte;
		logic       last_byte;
		logic       is_ext;
		logic       is_cap;
		logic       is_op;
	} item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] chan_width;
		logic       twt_support;
		logic       ofdma;
		logic       mu_mimo;
		logic       six_ghz;
		logic [5:0] color_code;
		logic       color_valid;
	} result_t;

endpackage

/* design/wifihe_front.sv */
module wifihe_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wifihe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     ie_byte,
	input  logic                           last_byte,
	input  logic                           q_full,
	output logic                           q_wr,
	output wifihe_pkg::item_t              q_item
);
	import wifihe_pkg::*;

	logic [7:0] ext_elem_id_q;
	logic [7:0] he_cap_ext_q;
	logic [7:0] he_op_ext_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_elem_id_q <= EXT_ELEM_ID_RST;
			he_cap_ext_q  <= HE_CAP_EXT_RST;
			he_op_ext_q   <= HE_OP_EXT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXT_ELEM_ID: ext_elem_id_q <= cfg_data;
				REG_HE_CAP_EXT:  he_cap_ext_q  <= cfg_data;
				REG_HE_OP_EXT:   he_op_ext_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// tag each byte with the compares the parser may need for it
	always_comb begin
		q_item.ie_byte   = ie_byte;
		q_item.last_byte = last_byte;
		q_item.is_ext    = (ie_byte == ext_elem_id_q);
		q_item.is_cap    = (ie_byte == he_cap_ext_q);
		q_item.is_op     = (ie_byte == he_op_ext_q);
	end

	assign full = q_full;
	assign q_wr = push && !q_full;

endmodule

/* design/wifihe_queue.sv */
module wifihe_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  wifihe_pkg::item_t wr_item,
	output logic              q_full,
	input  logic              rd,
	output logic              q_empty,
	output wifihe_pkg::item_t rd_item
);
	import wifihe_pkg::*;

	item_t          slot_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign q_full  = (count_q == (QAW+1)'(QDEPTH));
	assign q_empty = (count_q == '0);
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

/* design/wifihe_back.sv */
module wifihe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  wifihe_pkg::item_t   cur_it,
	output logic                q_rd,
	output logic                empty,
	input  logic                pop,
	output wifihe_pkg::result_t res
);
	import wifihe_pkg::*;

	typedef struct packed {
		phase_t     phase;
		logic       elem_is_ext;
		logic [7:0] bytes_left;
		logic [7:0] body_index;
		logic       cand_cap;
		logic       cand_op;
		logic [7:0] cand0;
		logic [7:0] cand1;
		logic [7:0] cand3;
		logic [7:0] cand6;
		logic       cap_found;
		logic [7:0] mac1;
		logic [7:0] mac3;
		logic [7:0] phy0;
		logic       cap_long;
		logic       op_found;
		logic [7:0] op0;
		logic [7:0] op3;
		logic       op_long;
	} pstate_t;

	pstate_t ps_q;
	pstate_t nxt;
	logic    fin;
	logic    fire;
	logic    res_valid_q;
	result_t res_q;
	result_t res_d;
	logic    op_ok;

	// a last byte needs a free result slot, anything else just runs
	assign fire  = !q_empty && (!cur_it.last_byte || !res_valid_q || pop);
	assign q_rd  = fire;
	assign empty = !res_valid_q;
	assign res   = res_q;

	always_comb begin
		nxt = ps_q;
		fin = 1'b0;
		unique case (ps_q.phase)
			PH_ID: begin
				nxt.elem_is_ext = cur_it.is_ext;
				nxt.phase       = PH_LEN;
			end
			PH_LEN: begin
				nxt.bytes_left = cur_it.ie_byte;
				nxt.body_index = '0;
				nxt.cand_cap   = 1'b0;
				nxt.cand_op    = 1'b0;
				nxt.cand0      = '0;
				nxt.cand1      = '0;
				nxt.cand3      = '0;
				nxt.cand6      = '0;
				nxt.phase      = (cur_it.ie_byte == '0) ? PH_ID : PH_EXT;
			end
			PH_EXT: begin
				nxt.bytes_left = ps_q.bytes_left - 1'b1;
				nxt.cand_cap   = ps_q.elem_is_ext && cur_it.is_cap && !ps_q.cap_found;
				nxt.cand_op    = ps_q.elem_is_ext && cur_it.is_op && !ps_q.op_found;
				if (nxt.bytes_left == '0) begin
					fin = 1'b1;
				end else begin
					nxt.phase = PH_BODY;
				end
			end
			PH_BODY: begin
				unique case (ps_q.body_index)
					IDX_OP0:  nxt.cand0 = cur_it.ie_byte;
					IDX_MAC1: nxt.cand1 = cur_it.ie_byte;
					IDX_MAC3: nxt.cand3 = cur_it.ie_byte;
					MAC_LEN:  nxt.cand6 = cur_it.ie_byte;
					default:  ;
				endcase
				nxt.body_index = ps_q.body_index + 1'b1;
				nxt.bytes_left = ps_q.bytes_left - 1'b1;
				fin = (nxt.bytes_left == '0);
			end
			default: ;
		endcase

		// element complete: keep it where it was a candidate
		if (fin) begin
			if (nxt.cand_cap) begin
				nxt.cap_found = 1'b1;
				nxt.mac1      = nxt.cand1;
				nxt.mac3      = nxt.cand3;
				nxt.phy0      = nxt.cand6;
				nxt.cap_long  = (nxt.body_index >= CAP_MIN);
			end
			if (nxt.cand_op) begin
				nxt.op_found = 1'b1;
				nxt.op0      = nxt.cand0;
				nxt.op3      = nxt.cand3;
				nxt.op_long  = (nxt.body_index >= OP_MIN_LEN);
			end
			nxt.cand_cap = 1'b0;
			nxt.cand_op  = 1'b0;
			nxt.phase    = PH_ID;
		end
	end

	// result from the state after this byte
	always_comb begin
		res_d = '0;
		op_ok = nxt.op_found && nxt.op_long;
		priority if (nxt.cap_found && !nxt.cap_long) begin
			res_d.status = ST_CAP_SHORT;
		end else if (nxt.cap_found) begin
			res_d.status = ST_HE_OK;
			priority if ((nxt.phy0 & PHY_BW160) != '0) res_d.chan_width = MHZ_160;
			else if ((nxt.phy0 & PHY_BW80) != '0)       res_d.chan_width = MHZ_80;
			else if ((nxt.phy0 & PHY_BW40) != '0)       res_d.chan_width = MHZ_40;
			else                                         res_d.chan_width = MHZ_20;
			res_d.twt_support = ((nxt.mac3 & MAC_TWT) != '0) ||
				(op_ok && ((nxt.op0 & OP_TWT) != '0));
			res_d.ofdma       = (nxt.mac1 & MAC_OFDMA) != '0;
			res_d.mu_mimo     = (nxt.phy0 & PHY_MUMIMO) != '0;
			res_d.six_ghz     = (nxt.phy0 & PHY_6GHZ) != '0;
			res_d.color_code  = op_ok ? nxt.op3[5:0] & COLOR_MASK[5:0] : '0;
			res_d.color_valid = op_ok;
		end else begin
			res_d.status = ST_NO_HE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				ps_q <= cur_it.last_byte ? pstate_t'('0) : nxt;
			end
			if (fire && cur_it.last_byte) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && cur_it.last_byte) begin
			res_q <= res_d;
		end
	end

`include "wifi_he_ie_scanner_core_assert.svh"

	`WIFIHE_ASSERT_NEXT(a_res_after_last, fire && cur_it.last_byte, res_valid_q, "no result after last beat")
	`WIFIHE_ASSERT_NEXT(a_parse_cleared, fire && cur_it.last_byte, ps_q.phase == PH_ID && !ps_q.cap_found && !ps_q.op_found, "parse state not cleared after list")
	`WIFIHE_ASSERT_IMPLY(a_fields_zero, res_valid_q && res_q.status != ST_HE_OK, res_q.chan_width == '0 && !res_q.color_valid && !res_q.twt_support, "fields set without HE")
	`WIFIHE_ASSERT_IMPLY(a_no_stall_lost, fire && cur_it.last_byte && res_valid_q, pop, "pending result overwritten")

endmodule

/* design/wifi_he_ie_scanner_core.sv */
// HE element scanner: push an 802.11 information element list one byte per beat
// (ie_byte, last_byte = 1 on the final byte) and pop one result per list,
// given after its last byte. The result reports whether a complete HE
// Capabilities element was found (status 0 none, 1 parsed, 2 capabilities
// body under 17 bytes) with channel width, TWT, OFDMA, MU-MIMO, 6 GHz and
// the BSS color from a complete HE Operation element. Only the first complete
// element of each kind counts; an element cut by the end of the list is
// ignored. Throughput is one byte per clock: the front end compares each
// byte against the three id registers and writes it into a four-beat queue,
// and the parser drains that queue one byte a cycle. The only stall is a
// last byte arriving while the previous result has not been popped yet; the
// parser then holds until pop, and push sees full once the queue fills.
// The last byte passes a queue slot, then the result register. The id
// registers are written through cfg_we, cfg_index and cfg_data; index 3 is
// ignored. The user writes them only while no list is in flight (not enforced).
module wifi_he_ie_scanner_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_we,
	input  logic [wifihe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                       cfg_data,
	// byte input
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       ie_byte,
	input  logic                             last_byte,
	// result output
	output logic                             empty,
	input  logic                             pop,
	output logic [1:0]                       status,
	output logic [7:0]                       chan_width,
	output logic                             twt_support,
	output logic                             ofdma,
	output logic                             mu_mimo,
	output logic                             six_ghz,
	output logic [5:0]                       color_code,
	output logic                             color_valid
);
	import wifihe_pkg::*;

	// front to queue
	logic    q_full;
	logic    q_wr;
	item_t   q_wr_item;
	// queue to back
	logic    q_empty;
	logic    q_rd;
	item_t   q_rd_item;
	result_t res;

	// id registers and byte classification
	wifihe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.ie_byte   (ie_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_item    (q_wr_item)
	);

	// short queue decoupling byte intake from the parser
	wifihe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_item (q_wr_item),
		.q_full  (q_full),
		.rd      (q_rd),
		.q_empty (q_empty),
		.rd_item (q_rd_item)
	);

	// record walker and result register
	wifihe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.cur_it  (q_rd_item),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign status      = res.status;
	assign chan_width  = res.chan_width;
	assign twt_support = res.twt_support;
	assign ofdma       = res.ofdma;
	assign mu_mimo     = res.mu_mimo;
	assign six_ghz     = res.six_ghz;
	assign color_code  = res.color_code;
	assign color_valid = res.color_valid;

endmodule
